// ===== design/lpcfc_pkg.sv =====
`default_nettype none
package lpcfc_pkg;
	localparam int IN_W = 20;
	localparam int CAM_W = 22;
	localparam int ACC_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FX = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FY = 3'd7;

	localparam logic [CAM_W-1:0] RANGE_MAX = {CAM_W{1'b1}};

	typedef struct packed {
		logic start;
		logic [45:0] value;
	} sqrt_req_t;

	typedef struct packed {
		logic done;
		logic [22:0] root;
	} sqrt_rsp_t;
endpackage
`default_nettype wire

// ===== design/lpcfc_sqrt.sv =====
`default_nettype none
module lpcfc_sqrt (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lpcfc_pkg::sqrt_req_t  req,
	output lpcfc_pkg::sqrt_rsp_t       rsp
);
	import lpcfc_pkg::*;

	logic [45:0] rem_q;
	logic [22:0] res_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [47:0] trial;
	logic [47:0] rem_ext;

	always_comb begin
		trial   = {23'd0, res_q, 2'b01} << {step_q, 1'b0};
		rem_ext = {2'd0, rem_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 5'd22;
			end else if (busy_q) begin
				if (step_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.value;
			res_q <= '0;
		end else if (busy_q) begin
			if (rem_ext >= trial) begin
				rem_q <= 46'(rem_ext - trial);
				res_q <= {res_q[21:0], 1'b1};
			end else begin
				res_q <= {res_q[21:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, res_q};
endmodule
`default_nettype wire

// ===== design/lidar_point_camera_frustum_cull.sv =====
// A new point is accepted only in ST_IDLE, after the previous one has left ST_OUT;
// a point that the cut-off or field-of-view test rejects does not wait for the root unit.
// The shared 23x23 multiplier runs 16 products in turn, then the root unit runs 23
// steps, one per cycle.
// A result still waiting in the output register holds the next point in ST_OUT.
// Reset (arst_n low) restores the identity transform, default camera, cleared statistics.
`default_nettype none
module lidar_point_camera_frustum_cull (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// lidar_x, lidar_y, lidar_z, then 4 zero bits
	input  wire logic [63:0] s_tdata,
	// frame_start
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// accepted, cam_x, cam_y, cam_z, point_range, frame_min_range,
	// frame_max_range, frame_has_points, then 2 zero bits
	output logic [135:0]     m_tdata
);
	import lpcfc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_SAT  = 7'b0000100,
		ST_FOV  = 7'b0001000,
		ST_SQ   = 7'b0010000,
		ST_ROOT = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [63:0] row_q [3];
	logic [7:0]  cut_q;
	logic [12:0] w_q, h_q;
	logic [15:0] fx_q, fy_q;
	logic [21:0] min_q, max_q;
	logic        any_q;

	logic signed [19:0] lx_q, ly_q, lz_q;
	logic        fs_q;
	logic [3:0]  k_q;
	logic signed [47:0] acc_q;
	logic signed [47:0] prod_s1;
	logic signed [21:0] cam_q [3];
	logic [47:0] sq_q;
	logic [47:0] lhs_q, rhs_q;
	logic        pass_q, acc_ok_q, inrange_q;
	logic [21:0] range_q;
	logic [135:0] out_q;
	logic        ovalid_q;

	logic signed [22:0] ma, mb;
	logic signed [45:0] mprod;
	logic [1:0] row_i;
	logic [1:0] col_i;
	logic [15:0] coef;
	logic signed [47:0] rounded;
	logic signed [21:0] satv;
	logic [21:0] absx, absy;
	sqrt_req_t sreq;
	sqrt_rsp_t srsp;
	logic [21:0] rng_sat;
	logic [21:0] nmin, nmax;
	logic        nany, fin_acc;

	function automatic logic [21:0] mag22(input logic signed [21:0] v);
		return v[21] ? 22'(-v) : 22'(v);
	endfunction

	// k 0..8: matrix terms, 9..12: fov products, 13..15: squares
	always_comb begin
		unique case (k_q) inside
			4'd0, 4'd1, 4'd2: row_i = 2'd0;
			4'd3, 4'd4, 4'd5: row_i = 2'd1;
			default: row_i = 2'd2;
		endcase
		unique case (k_q) inside
			4'd0, 4'd3, 4'd6: col_i = 2'd0;
			4'd1, 4'd4, 4'd7: col_i = 2'd1;
			default: col_i = 2'd2;
		endcase
		coef  = row_q[row_i][63-16*col_i -: 16];
		absx  = mag22(cam_q[0]);
		absy  = mag22(cam_q[1]);
		ma = '0;
		mb = '0;
		if (k_q < 4'd9) begin
			ma = 23'(signed'(coef));
			mb = (col_i == 2'd0) ? 23'(lx_q) : (col_i == 2'd1) ? 23'(ly_q) : 23'(lz_q);
		end else begin
			unique case (k_q)
				4'd9:  begin ma = signed'({1'b0, absx}); mb = signed'({6'd0, fx_q, 1'b0}); end
				4'd10: begin ma = signed'({1'b0, cam_q[2]}); mb = signed'({10'd0, w_q}); end
				4'd11: begin ma = signed'({1'b0, absy}); mb = signed'({6'd0, fy_q, 1'b0}); end
				4'd12: begin ma = signed'({1'b0, cam_q[2]}); mb = signed'({10'd0, h_q}); end
				4'd13: begin ma = signed'({1'b0, absx}); mb = signed'({1'b0, absx}); end
				4'd14: begin ma = signed'({1'b0, absy}); mb = signed'({1'b0, absy}); end
				4'd15: begin ma = signed'({1'b0, mag22(cam_q[2])}); mb = signed'({1'b0, mag22(cam_q[2])}); end
				default: ;
			endcase
		end
		mprod = ma * mb;
		rounded = (acc_q + 48'sd8192) >>> 14;
		if (rounded > 48'sd2097151) satv = 22'sd2097151;
		else if (rounded < -48'sd2097152) satv = -22'sd2097152;
		else satv = 22'(rounded);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 48'(mprod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 64'd4611686018427387904;
			row_q[1] <= 64'd70368744177664;
			row_q[2] <= 64'd1073741824;
			cut_q <= 8'd50;
			w_q <= 13'd1920;
			h_q <= 13'd1080;
			fx_q <= 16'd1000;
			fy_q <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_X:  row_q[0] <= cfg_data;
				REG_ROW_Y:  row_q[1] <= cfg_data;
				REG_ROW_Z:  row_q[2] <= cfg_data;
				REG_CUTOFF: cut_q <= cfg_data[7:0];
				REG_WIDTH:  w_q <= cfg_data[12:0];
				REG_HEIGHT: h_q <= cfg_data[12:0];
				REG_FX:     fx_q <= cfg_data[15:0];
				REG_FY:     fy_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [3:0] sub_q;

	always_comb begin
		sreq.start = (state_q == ST_SQ) && (sub_q == 4'd5);
		sreq.value = 46'(sq_q + prod_s1);
		rng_sat = srsp.root[22] ? RANGE_MAX : srsp.root[21:0];
		fin_acc = inrange_q && acc_ok_q;
		nmin = fs_q ? RANGE_MAX : min_q;
		nmax = fs_q ? 22'd0 : max_q;
		nany = fs_q ? 1'b0 : any_q;
		if (fin_acc) begin
			if (range_q < nmin) nmin = range_q;
			if (range_q > nmax) nmax = range_q;
			nany = 1'b1;
		end
	end

	lpcfc_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(srsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			min_q    <= RANGE_MAX;
			max_q    <= '0;
			any_q    <= 1'b0;
			k_q      <= '0;
			sub_q    <= '0;
		end else begin
			if (state_q == ST_OUT && (!ovalid_q || m_tready)) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					k_q <= '0;
					sub_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// odd sub: product registered, accumulate
					sub_q <= sub_q + 4'd1;
					if (sub_q[0]) begin
						if (col_i == 2'd2) state_q <= ST_SAT;
						else k_q <= k_q + 4'd1;
					end
				end
				ST_SAT: begin
					if (k_q == 4'd8) begin
						k_q <= 4'd9;
						sub_q <= '0;
						state_q <= ST_FOV;
					end else begin
						k_q <= k_q + 4'd1;
						sub_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_FOV: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q[0]) begin
						if (k_q == 4'd12) begin
							k_q <= 4'd13;
							sub_q <= '0;
							state_q <= ST_SQ;
						end else k_q <= k_q + 4'd1;
					end
				end
				ST_SQ: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q[0] && k_q != 4'd15) k_q <= k_q + 4'd1;
					if (sub_q == 4'd5) state_q <= ST_ROOT;
				end
				ST_ROOT: if (srsp.done || !fin_acc) state_q <= ST_OUT;
				ST_OUT: if (!ovalid_q || m_tready) begin
					min_q <= nmin;
					max_q <= nmax;
					any_q <= nany;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				lx_q <= signed'(s_tdata[19:0]);
				ly_q <= signed'(s_tdata[39:20]);
				lz_q <= signed'(s_tdata[59:40]);
				fs_q <= s_tuser;
				inrange_q <= !s_tdata[19] &&
					({12'd0, s_tdata[19:0]} <= 32'(cut_q) * 32'd1000);
				acc_q <= 48'(signed'(row_q[0][15:0])) <<< 14;
			end
			ST_MUL: if (sub_q[0]) acc_q <= acc_q + prod_s1;
			ST_SAT: begin
				cam_q[row_i] <= satv;
				if (k_q != 4'd8) acc_q <= 48'(signed'(row_q[row_i + 2'd1][15:0])) <<< 14;
			end
			ST_FOV: if (sub_q[0]) begin
				unique case (k_q)
					4'd9:  lhs_q <= prod_s1;
					4'd10: pass_q <= !cam_q[2][21] && cam_q[2] != 0 && lhs_q <= prod_s1;
					4'd11: lhs_q <= prod_s1;
					default: pass_q <= pass_q && lhs_q <= prod_s1;
				endcase
			end
			ST_SQ: begin
				if (sub_q == 4'd0) begin
					acc_ok_q <= pass_q || (cam_q[0] == 0 && cam_q[1] == 0 && cam_q[2] == 0);
					sq_q <= '0;
				end
				if (sub_q[0]) sq_q <= sq_q + prod_s1;
			end
			ST_ROOT: range_q <= fin_acc ? rng_sat : 22'd0;
			ST_OUT: if (!ovalid_q || m_tready) begin
				out_q <= {2'd0, nany, nmax, nmin, range_q,
					inrange_q ? cam_q[2] : 22'd0, inrange_q ? cam_q[1] : 22'd0,
					inrange_q ? cam_q[0] : 22'd0, fin_acc};
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q));
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready);
endmodule
`default_nettype wire

// ===== tb/lpcfc_checker.sv =====
`timescale 1ns / 100ps
module lpcfc_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [63:0]  s_tdata,
	input  wire logic         s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [135:0] m_tdata,
	output int                errors,
	output int                pending
);
	import lpcfc_pkg::*;

	typedef struct packed {
		logic            accepted;
		logic [CAM_W-1:0] cam_x;
		logic [CAM_W-1:0] cam_y;
		logic [CAM_W-1:0] cam_z;
		logic [CAM_W-1:0] rng;
		logic [CAM_W-1:0] min_rng;
		logic [CAM_W-1:0] max_rng;
		logic            has_points;
	} cull_result_t;

	logic [63:0] row_x, row_y, row_z;
	logic [7:0]  cutoff_m;
	logic [12:0] width_px, height_px;
	logic [15:0] fx_px, fy_px;
	logic [CAM_W-1:0] min_seen, max_seen;
	logic        any_seen;
	cull_result_t expected_points[$];

	function automatic longint signed transform_row(logic [63:0] row, longint signed x,
			longint signed y, longint signed z);
		longint signed a, b, c, t, acc;
		a = longint'($signed(row[63:48]));
		b = longint'($signed(row[47:32]));
		c = longint'($signed(row[31:16]));
		t = longint'($signed(row[15:0]));
		acc = a * x + b * y + c * z + t * 16384 + 8192;
		acc = acc >>> 14;
		if (acc > 2097151)
			acc = 2097151;
		if (acc < -2097152)
			acc = -2097152;
		return acc;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned magnitude(longint signed v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	task automatic cull_point(logic [63:0] data, logic frame_start);
		longint signed lx, ly, lz, cx, cy, cz;
		longint unsigned rng, zu;
		logic acc;
		cull_result_t r;
		lx = longint'($signed(data[19:0]));
		ly = longint'($signed(data[39:20]));
		lz = longint'($signed(data[59:40]));
		cx = 0;
		cy = 0;
		cz = 0;
		rng = 0;
		acc = 1'b0;
		if (frame_start) begin
			min_seen = RANGE_MAX;
			max_seen = '0;
			any_seen = 1'b0;
		end
		if (lx >= 0 && lx <= longint'(cutoff_m) * 1000) begin
			cx = transform_row(row_x, lx, ly, lz);
			cy = transform_row(row_y, lx, ly, lz);
			cz = transform_row(row_z, lx, ly, lz);
			if (cx == 0 && cy == 0 && cz == 0) begin
				acc = 1'b1;
			end else if (cz > 0) begin
				zu = longint'(cz);
				acc = (2 * longint'(fx_px) * magnitude(cx) <= longint'(width_px) * zu) &&
					(2 * longint'(fy_px) * magnitude(cy) <= longint'(height_px) * zu);
			end
			if (acc) begin
				rng = int_sqrt(magnitude(cx) * magnitude(cx) + magnitude(cy) * magnitude(cy)
					+ magnitude(cz) * magnitude(cz));
				if (rng > longint'(RANGE_MAX))
					rng = longint'(RANGE_MAX);
				if (rng[CAM_W-1:0] < min_seen)
					min_seen = rng[CAM_W-1:0];
				if (rng[CAM_W-1:0] > max_seen)
					max_seen = rng[CAM_W-1:0];
				any_seen = 1'b1;
			end
		end
		r.accepted = acc;
		r.cam_x = cx[CAM_W-1:0];
		r.cam_y = cy[CAM_W-1:0];
		r.cam_z = cz[CAM_W-1:0];
		r.rng = rng[CAM_W-1:0];
		r.min_rng = min_seen;
		r.max_rng = max_seen;
		r.has_points = any_seen;
		expected_points.insert(expected_points.size(), r);
	endtask

	task automatic report_mismatch(string field, logic [CAM_W-1:0] got, logic [CAM_W-1:0] want);
		$display("mismatch at %0t: %s got %0h, expected %0h", $time, field, got, want);
		errors++;
	endtask

	task automatic compare_result(logic [135:0] d);
		cull_result_t w;
		if (expected_points.size() == 0) begin
			$display("mismatch at %0t: result transaction with nothing expected", $time);
			errors++;
			return;
		end
		w = expected_points.pop_front();
		if (d[0] !== w.accepted)
			report_mismatch("accepted", CAM_W'(d[0]), CAM_W'(w.accepted));
		if (d[22:1] !== w.cam_x)
			report_mismatch("cam_x", d[22:1], w.cam_x);
		if (d[44:23] !== w.cam_y)
			report_mismatch("cam_y", d[44:23], w.cam_y);
		if (d[66:45] !== w.cam_z)
			report_mismatch("cam_z", d[66:45], w.cam_z);
		if (d[88:67] !== w.rng)
			report_mismatch("point_range", d[88:67], w.rng);
		if (d[110:89] !== w.min_rng)
			report_mismatch("frame_min_range", d[110:89], w.min_rng);
		if (d[132:111] !== w.max_rng)
			report_mismatch("frame_max_range", d[132:111], w.max_rng);
		if (d[133] !== w.has_points)
			report_mismatch("frame_has_points", CAM_W'(d[133]), CAM_W'(w.has_points));
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x = 64'h4000_0000_0000_0000;
			row_y = 64'h0000_4000_0000_0000;
			row_z = 64'h0000_0000_4000_0000;
			cutoff_m = 8'd50;
			width_px = 13'd1920;
			height_px = 13'd1080;
			fx_px = 16'd1000;
			fy_px = 16'd1000;
			min_seen = RANGE_MAX;
			max_seen = '0;
			any_seen = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_X: row_x = cfg_data;
					REG_ROW_Y: row_y = cfg_data;
					REG_ROW_Z: row_z = cfg_data;
					REG_CUTOFF: cutoff_m = cfg_data[7:0];
					REG_WIDTH: width_px = cfg_data[12:0];
					REG_HEIGHT: height_px = cfg_data[12:0];
					REG_FX: fx_px = cfg_data[15:0];
					REG_FY: fy_px = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				cull_point(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				compare_result(m_tdata);
		end
		pending = expected_points.size();
	end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
	import lpcfc_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEMS_PER_PHASE = 270;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	int           errors;
	int           pending;
	int           cycles;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           cutoff_mm;

	lidar_point_camera_frustum_cull u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	lpcfc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cycles = 0;
	end

	always #1 clk = ~clk;

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_point(int x, int y, int z, logic frame_start);
		logic rdy;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, z[19:0], y[19:0], x[19:0]};
		s_tuser <= frame_start;
		forever begin
			rdy = s_tready;
			@(negedge clk);
			if (rdy)
				break;
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (45) @(negedge clk);
	endtask

	task automatic configure(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz, logic [7:0] cut,
			logic [12:0] w, logic [12:0] h, logic [15:0] fx, logic [15:0] fy);
		write_reg(REG_ROW_X, rx);
		write_reg(REG_ROW_Y, ry);
		write_reg(REG_ROW_Z, rz);
		write_reg(REG_CUTOFF, 64'(cut));
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
		write_reg(REG_FX, 64'(fx));
		write_reg(REG_FY, 64'(fy));
		cfg_we <= 1'b0;
		@(negedge clk);
		cutoff_mm = int'(cut) * 1000;
	endtask

	task automatic random_points(int count);
		int x, y, z, span;
		repeat (count) begin
			if ($urandom_range(0, 99) < 75) begin
				x = $urandom_range(0, cutoff_mm);
				span = (x > 0) ? x : 1;
				y = int'($urandom_range(0, 2 * span)) - span;
				z = int'($urandom_range(0, 2 * span)) - span;
				if ($urandom_range(0, 3) == 0) begin
					y = y / 4;
					z = z / 4;
				end
			end else begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end
			send_point(x, y, z, $urandom_range(0, 19) == 0);
		end
	endtask

	logic [63:0] cam_rx, cam_ry, cam_rz;

	initial begin
		cam_rx = {16'h0000, 16'hC000, 16'h0000, 16'h0000};
		cam_ry = {16'h0000, 16'h0000, 16'hC000, 16'h0000};
		cam_rz = {16'h4000, 16'h0000, 16'h0000, 16'h0000};
		cutoff_mm = 50000;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: identity transform, 50 m cut-off
		send_point(0, 0, 0, 1'b1);
		send_point(-1, 0, 100, 1'b0);
		send_point(-524288, -524288, -524288, 1'b0);
		send_point(50000, 0, 100000, 1'b0);
		send_point(50001, 0, 100000, 1'b0);
		send_point(1000, 0, 0, 1'b0);
		send_point(1000, 0, -5, 1'b0);
		send_point(960, 540, 1000, 1'b0);
		send_point(961, 540, 1000, 1'b0);
		send_point(960, 541, 1000, 1'b0);
		send_point(0, 524287, 524287, 1'b0);
		send_point(10, -524288, 524287, 1'b0);
		send_point(3, 4, 12, 1'b0);
		send_point(0, 0, 0, 1'b1);
		send_point(524287, 0, 1000, 1'b0);
		send_point(20000, -10000, 30000, 1'b1);
		send_point(0, 0, 1, 1'b0);
		drain();

		for (int k = 0; k < 6; k++) begin
			case (k % 3)
				0: begin send_idle_pct = 11; recv_idle_pct = 82; end
				1: begin send_idle_pct = 82; recv_idle_pct = 11; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (k)
				0: configure(cam_rx, cam_ry, cam_rz, 8'd255, 13'd8191, 13'd8191, 16'd1, 16'd1);
				1: configure(cam_rx, cam_ry, cam_rz, 8'd0, 13'd1, 13'd1, 16'd65535, 16'd65535);
				2: configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					8'($urandom), 13'($urandom), 13'($urandom), 16'($urandom), 16'($urandom));
				3: configure(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
					64'h7FFF_8000_7FFF_8000, 8'd255, 13'd0, 13'd0, 16'd0, 16'd0);
				4: configure(cam_rx | 64'h0000_0000_0000_7FFF, cam_ry | 64'h0000_0000_0000_8000,
					cam_rz | 64'h0000_0000_0000_FC18, 8'd100, 13'd1920, 13'd1080,
					16'd1000, 16'd1000);
				default: configure(cam_rx, cam_ry, cam_rz, 8'd30, 13'd4000, 13'd3000,
					16'd700, 16'd900);
			endcase
			if (k == 3) begin
				send_point(524287, 524287, 524287, 1'b1);
				send_point(255000, -524288, -524288, 1'b0);
			end
			random_points(ITEMS_PER_PHASE);
			drain();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
